>>> rtl/i2cms_pkg.sv
// Shared types, command codes and bus segment codes for the I2C master byte sequencer.
package i2cms_pkg;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_STOP  = 3'd4;

    localparam logic [2:0] CMD_IDLE = 3'd0;

    localparam logic [3:0] SEG_START = 4'd0;
    localparam logic [3:0] SEG_FIRST = 4'd1;
    localparam logic [3:0] SEG_ACK   = 4'd9;
    localparam logic [3:0] SEG_STOP  = 4'd10;

    localparam logic [1:0] PH_LOW_A = 2'd0;
    localparam logic [1:0] PH_HIGH  = 2'd1;
    localparam logic [1:0] PH_LOW_B = 2'd2;

    localparam int FQ_DEPTH = 4;
    localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
    localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

    typedef struct packed {
        logic [2:0] op;
        logic [6:0] target_address;
        logic       read_not_write;
        logic [7:0] data_byte;
        logic       ack_more;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        logic       busy_res;
        logic       command_done;
        logic [7:0] received_byte;
        logic       nack_seen;
    } t_result;

    typedef struct packed {
        logic       is_cmd;
        logic [2:0] op;
        logic [7:0] load_byte;
        logic       ack_more;
        logic       sda_in;
    } t_entry;

endpackage

>>> rtl/i2c_master_byte_sequencer_unit.sv
// Top level of the I2C master byte sequencer: front end, bus engine and result queue.
//
// Transactions enter through a queue-style port: an item is taken when push is high
// and full is low. Each item is either a command (start with address, write byte,
// read byte, stop) or a tick that advances the bus by one phase. Commands give no
// result; unknown op codes are dropped at the front end. Every tick gives exactly
// one result with the SCL level, the SDA pull-low, busy, done, the last read byte
// and the NACK flag.
// Results leave through a second queue: the oldest result sits on o_result while
// empty is low and is taken when pop is high.
// A tick is first registered in the front queue; the engine reads it from there and
// writes its result into the result queue as it does so, and that queue registers it.
// An item can be taken every cycle while full is low; the engine retires one per cycle.
// When the receiver stalls, the two-entry result queue fills, the engine holds
// ticks (commands still drain), and full rises once the front queue is also full.
// Reset empties both queues and returns the bus to idle with SCL high, SDA released.
module i2c_master_byte_sequencer_unit
    import i2cms_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    push,
    output logic    full,
    input  t_item   i_item,
    output logic    empty,
    input  logic    pop,
    output t_result o_result
);

    logic    q_valid;
    t_entry  q_entry;
    logic    q_take;
    logic    res_full;
    logic    res_push;
    t_result res;

    i2cms_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .o_full  (full),
        .o_valid (q_valid),
        .o_entry (q_entry),
        .i_take  (q_take)
    );

    i2cms_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_entry    (q_entry),
        .o_take     (q_take),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_result   (res)
    );

    i2cms_out_queue u_out_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (res_push),
        .i_result (res),
        .o_full   (res_full),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (o_result)
    );

endmodule

>>> rtl/i2cms_front.sv
// Front end: classifies incoming transactions and queues them for the bus engine.
module i2cms_front
    import i2cms_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_item,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_entry,
    input  logic   i_take
);

    t_entry                r_mem [FQ_DEPTH];
    logic [FQ_PTR_W-1:0]   r_wr;
    logic [FQ_PTR_W-1:0]   r_rd;
    logic [FQ_CNT_W-1:0]   r_cnt;
    t_entry                entry;
    logic                  keep;
    logic                  do_wr;
    logic                  do_rd;

    always_comb begin
        keep            = i_item.op inside {[OP_TICK:OP_STOP]};
        entry.is_cmd    = (i_item.op != OP_TICK);
        entry.op        = i_item.op;
        entry.ack_more  = i_item.ack_more;
        entry.sda_in    = i_item.sda_in;
        case (i_item.op)
            OP_START: entry.load_byte = {i_item.target_address, i_item.read_not_write};
            OP_WRITE: entry.load_byte = i_item.data_byte;
            default:  entry.load_byte = 8'd0;
        endcase
    end

    assign o_full  = (r_cnt == FQ_CNT_W'(FQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];
    assign do_wr   = i_push && !o_full && keep;
    assign do_rd   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr] <= entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_rd) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!do_wr && do_rd) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> rtl/i2cms_engine.sv
// Back end: the bus phase engine that runs commands and produces one result per tick.
module i2cms_engine
    import i2cms_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_entry  i_entry,
    output logic    o_take,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_result
);

    logic [2:0] r_cmd;
    logic [1:0] r_phase;
    logic [3:0] r_seg;
    logic [7:0] r_shift;
    logic       r_ack;
    logic       r_nack;
    logic       r_scl;
    logic       r_pull;
    logic [7:0] r_last;

    logic [2:0] n_cmd;
    logic [1:0] n_phase;
    logic [3:0] n_seg;
    logic [7:0] n_shift;
    logic       n_ack;
    logic       n_nack;
    logic       n_scl;
    logic       n_pull;
    logic [7:0] n_last;

    logic       is_read;
    logic       done;

    assign o_take  = i_valid && (i_entry.is_cmd || !i_res_full);
    assign is_read = (r_cmd == OP_READ);

    always_comb begin
        n_cmd      = r_cmd;
        n_phase    = r_phase;
        n_seg      = r_seg;
        n_shift    = r_shift;
        n_ack      = r_ack;
        n_nack     = r_nack;
        n_scl      = r_scl;
        n_pull     = r_pull;
        n_last     = r_last;
        done       = 1'b0;
        o_res_push = 1'b0;

        if (o_take && i_entry.is_cmd) begin
            if (r_cmd == CMD_IDLE) begin
                n_cmd   = i_entry.op;
                n_phase = PH_LOW_A;
                n_nack  = 1'b0;
                case (i_entry.op)
                    OP_START: begin
                        n_shift = i_entry.load_byte;
                        n_seg   = SEG_START;
                    end
                    OP_WRITE: begin
                        n_shift = i_entry.load_byte;
                        n_seg   = SEG_FIRST;
                    end
                    OP_READ: begin
                        n_shift = 8'd0;
                        n_ack   = i_entry.ack_more;
                        n_seg   = SEG_FIRST;
                    end
                    default: begin
                        n_seg = SEG_STOP;
                    end
                endcase
            end
        end else if (o_take) begin
            o_res_push = 1'b1;
            if (r_cmd != CMD_IDLE) begin
                if (r_seg == SEG_START) begin
                    n_scl  = (r_phase != PH_LOW_B);
                    n_pull = (r_phase != PH_LOW_A);
                end else if (r_seg == SEG_STOP) begin
                    n_scl  = (r_phase != PH_LOW_A);
                    n_pull = (r_phase != PH_LOW_B);
                end else if (r_seg < SEG_ACK) begin
                    n_scl = (r_phase == PH_HIGH);
                    if (is_read) begin
                        n_pull = 1'b0;
                        if (r_phase == PH_HIGH) begin
                            n_shift = {r_shift[6:0], i_entry.sda_in};
                        end
                    end else begin
                        n_pull = !r_shift[7];
                    end
                end else begin
                    n_scl = (r_phase == PH_HIGH);
                    if (is_read) begin
                        n_pull = r_ack;
                    end else begin
                        n_pull = 1'b0;
                        if (r_phase == PH_HIGH && i_entry.sda_in) begin
                            n_nack = 1'b1;
                        end
                    end
                end

                if (r_phase < PH_LOW_B) begin
                    n_phase = r_phase + 2'd1;
                end else begin
                    n_phase = PH_LOW_A;
                    if (r_seg >= SEG_FIRST && r_seg < SEG_ACK && !is_read) begin
                        n_shift = {r_shift[6:0], 1'b0};
                    end
                    if (r_seg == SEG_ACK) begin
                        if (!is_read && n_nack) begin
                            n_seg = SEG_STOP;
                        end else begin
                            if (is_read) begin
                                n_last = n_shift;
                            end
                            done = 1'b1;
                        end
                    end else if (r_seg >= SEG_STOP) begin
                        done = 1'b1;
                    end else begin
                        n_seg = r_seg + 4'd1;
                    end
                    if (done) begin
                        n_cmd = CMD_IDLE;
                        n_seg = SEG_START;
                    end
                end
            end
        end

        o_result.scl_level     = n_scl;
        o_result.sda_pull_low  = n_pull;
        o_result.busy_res      = (n_cmd != CMD_IDLE);
        o_result.command_done  = done;
        o_result.received_byte = n_last;
        o_result.nack_seen     = n_nack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd   <= CMD_IDLE;
            r_phase <= PH_LOW_A;
            r_seg   <= SEG_START;
            r_shift <= 8'd0;
            r_ack   <= 1'b0;
            r_nack  <= 1'b0;
            r_scl   <= 1'b1;
            r_pull  <= 1'b0;
            r_last  <= 8'd0;
        end else begin
            r_cmd   <= n_cmd;
            r_phase <= n_phase;
            r_seg   <= n_seg;
            r_shift <= n_shift;
            r_ack   <= n_ack;
            r_nack  <= n_nack;
            r_scl   <= n_scl;
            r_pull  <= n_pull;
            r_last  <= n_last;
        end
    end

endmodule

>>> rtl/i2cms_out_queue.sv
// Two-entry result queue that decouples the bus engine from the result receiver.
module i2cms_out_queue
    import i2cms_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    t_result    r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       do_wr;
    logic       do_rd;

    assign o_full   = (r_cnt == 2'd2);
    assign o_empty  = (r_cnt == 2'd0);
    assign o_result = r_mem[r_rd];
    assign do_wr    = i_push && !o_full;
    assign do_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr] <= i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_wr) begin
                r_wr <= !r_wr;
            end
            if (do_rd) begin
                r_rd <= !r_rd;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!do_wr && do_rd) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

>>> bench/i2c_master_byte_sequencer_unit_tb.sv
// Self-checking testbench for the I2C master byte sequencer with a bus-phase predictor.
module i2c_master_byte_sequencer_unit_tb;
    import i2cms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned HOLD_AT_RESULT = 400;
    localparam int unsigned HOLD_CYCLES = 150;
    localparam int unsigned FIRST_HALF = 975;
    localparam int unsigned ITEM_TARGET = 1950;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    push = 1'b0;
    logic    pop = 1'b0;
    logic    full;
    logic    empty;
    t_item   i_item = '0;
    t_result o_result;

    t_item   pending_bus_items[$];
    t_result expected_phases[$];

    logic [2:0] bus_cmd = CMD_IDLE;
    logic [1:0] bus_phase = PH_LOW_A;
    logic [3:0] bus_seg = SEG_START;
    logic [7:0] shift_reg = '0;
    logic       ack_sel = 1'b0;
    logic       nack_flag = 1'b0;
    logic       pin_scl = 1'b1;
    logic       pin_pull = 1'b0;
    logic [7:0] last_read = '0;

    int unsigned items_queued = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;
    int unsigned push_wait = 0;
    int unsigned pop_wait = 0;
    int unsigned push_calm = 0;
    int unsigned pop_calm = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    i2c_master_byte_sequencer_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic advance_bus(input t_item it);
        logic       scl;
        logic       pull;
        logic       done;
        logic [3:0] seg;
        logic [1:0] ph;
        t_result    r;
        if (it.op != OP_TICK) begin
            if (bus_cmd == CMD_IDLE && it.op <= OP_STOP) begin
                bus_cmd = it.op;
                bus_phase = PH_LOW_A;
                nack_flag = 1'b0;
                case (it.op)
                    OP_START: begin
                        shift_reg = {it.target_address, it.read_not_write};
                        bus_seg = SEG_START;
                    end
                    OP_WRITE: begin
                        shift_reg = it.data_byte;
                        bus_seg = SEG_FIRST;
                    end
                    OP_READ: begin
                        shift_reg = '0;
                        ack_sel = it.ack_more;
                        bus_seg = SEG_FIRST;
                    end
                    default: begin
                        bus_seg = SEG_STOP;
                    end
                endcase
            end
        end else if (bus_cmd == CMD_IDLE) begin
            r = '{pin_scl, pin_pull, 1'b0, 1'b0, last_read, nack_flag};
            expected_phases.push_back(r);
        end else begin
            seg = bus_seg;
            ph = bus_phase;
            done = 1'b0;
            scl = (ph == PH_HIGH);
            pull = 1'b0;
            if (seg == SEG_START) begin
                scl = (ph != PH_LOW_B);
                pull = (ph != PH_LOW_A);
            end else if (seg == SEG_STOP) begin
                scl = (ph != PH_LOW_A);
                pull = (ph != PH_LOW_B);
            end else if (seg < SEG_ACK) begin
                if (bus_cmd == OP_READ) begin
                    if (ph == PH_HIGH) begin
                        shift_reg = {shift_reg[6:0], it.sda_in};
                    end
                end else begin
                    pull = !shift_reg[7];
                end
            end else if (bus_cmd == OP_READ) begin
                pull = ack_sel;
            end else if (ph == PH_HIGH && it.sda_in) begin
                nack_flag = 1'b1;
            end

            if (ph != PH_LOW_B) begin
                bus_phase = ph + 2'd1;
            end else begin
                bus_phase = PH_LOW_A;
                if (seg >= SEG_FIRST && seg < SEG_ACK && bus_cmd != OP_READ) begin
                    shift_reg = {shift_reg[6:0], 1'b0};
                end
                if (seg == SEG_ACK) begin
                    if (bus_cmd != OP_READ && nack_flag) begin
                        bus_seg = SEG_STOP;
                    end else begin
                        if (bus_cmd == OP_READ) begin
                            last_read = shift_reg;
                        end
                        done = 1'b1;
                    end
                end else if (seg >= SEG_STOP) begin
                    done = 1'b1;
                end else begin
                    bus_seg = seg + 4'd1;
                end
                if (done) begin
                    bus_cmd = CMD_IDLE;
                    bus_seg = SEG_START;
                end
            end

            pin_scl = scl;
            pin_pull = pull;
            r = '{scl, pull, bus_cmd != CMD_IDLE, done, last_read, nack_flag};
            expected_phases.push_back(r);
        end
    endtask

    function automatic void compare_field(input string field, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    task automatic check_phase(input t_result got);
        t_result want;
        if (expected_phases.size() == 0) begin
            $display("%0t: unexpected transaction, actual %p", $time, got);
            mismatches++;
        end else begin
            want = expected_phases.pop_front();
            compare_field("scl_level", want.scl_level, got.scl_level);
            compare_field("sda_pull_low", want.sda_pull_low, got.sda_pull_low);
            compare_field("busy_res", want.busy_res, got.busy_res);
            compare_field("command_done", want.command_done, got.command_done);
            compare_field("received_byte", want.received_byte, got.received_byte);
            compare_field("nack_seen", want.nack_seen, got.nack_seen);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                advance_bus(i_item);
                push_wait = pick_gap(push_calm);
            end
            if (push && full) begin
                push <= 1'b1;
            end else if (push_wait > 0) begin
                push_wait--;
                push <= 1'b0;
            end else if (pending_bus_items.size() > 0) begin
                push <= 1'b1;
                i_item <= pending_bus_items.pop_front();
            end else begin
                push <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                check_phase(o_result);
                results_seen++;
                pop_wait = pick_gap(pop_calm);
            end
            if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (pop_wait > 0) begin
                pop_wait--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic t_item rand_item(input logic [2:0] op, input logic sda);
        t_item it;
        it = t_item'($urandom);
        it.op = op;
        it.sda_in = sda;
        return it;
    endfunction

    task automatic add_item(input t_item it);
        pending_bus_items.push_back(it);
        items_queued++;
    endtask

    task automatic add_command(input logic [2:0] op);
        t_item       cmd;
        logic        nack;
        int unsigned ticks;
        int unsigned ack_at;
        int unsigned noise_at;
        int unsigned r;
        cmd = rand_item(op, 1'b0);
        if ($urandom_range(0, 5) == 0) begin
            cmd.target_address = $urandom_range(0, 1) ? 7'h7f : 7'h00;
            cmd.data_byte = $urandom_range(0, 1) ? 8'hff : 8'h00;
        end
        add_item(cmd);
        nack = ($urandom_range(0, 3) == 0);
        case (op)
            OP_START: begin
                ticks = 30;
                ack_at = 28;
            end
            OP_WRITE: begin
                ticks = 27;
                ack_at = 25;
            end
            OP_READ: begin
                ticks = 27;
                ack_at = ticks;
                nack = 1'b0;
            end
            default: begin
                ticks = 3;
                ack_at = ticks;
                nack = 1'b0;
            end
        endcase
        if (nack) begin
            ticks += 3;
        end
        r = $urandom_range(0, 99);
        if (r < 6) begin
            ticks = $urandom_range(0, ticks - 1);
        end else if (r < 14) begin
            ticks += $urandom_range(1, 3);
        end
        noise_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, ticks) : ticks + 1;
        for (int unsigned k = 0; k <= ticks; k++) begin
            if (k == noise_at) begin
                pending_bus_items.push_back(rand_item(3'($urandom_range(1, 7)), 1'b0));
            end
            if (k < ticks) begin
                add_item(rand_item(OP_TICK, (k == ack_at) ? nack : 1'($urandom_range(0, 1))));
            end
        end
    endtask

    task automatic add_transfer();
        int unsigned n;
        n = $urandom_range(1, 3);
        add_command(OP_START);
        repeat (n) begin
            add_command($urandom_range(0, 1) ? OP_WRITE : OP_READ);
        end
        if ($urandom_range(0, 9) != 0) begin
            add_command(OP_STOP);
        end
    endtask

    task automatic fill_until(input int unsigned target);
        while (items_queued < target) begin
            if ($urandom_range(0, 9) == 0) begin
                add_command(3'($urandom_range(1, 4)));
            end else begin
                add_transfer();
            end
        end
    endtask

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_bus_items.size() != 0 || push || expected_phases.size() != 0);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_item(rand_item(OP_TICK, 1'b0));
        add_item(rand_item(OP_TICK, 1'b1));
        pending_bus_items.push_back(rand_item(3'd5, 1'b0));
        pending_bus_items.push_back(rand_item(3'd6, 1'b1));
        pending_bus_items.push_back(rand_item(3'd7, 1'b0));
        add_item(rand_item(OP_STOP, 1'b0));
        pending_bus_items.push_back(rand_item(OP_READ, 1'b0));
        add_item(rand_item(OP_TICK, 1'b1));
        add_item(rand_item(OP_TICK, 1'b0));
        add_item(rand_item(OP_TICK, 1'b1));
        add_item(rand_item(OP_TICK, 1'b0));
        wait_drained();

        fill_until(FIRST_HALF);
        wait_drained();

        fill_until(ITEM_TARGET);
        wait_drained();
        repeat (10) @(negedge i_clk);

        if (mismatches == 0 && expected_phases.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/i2cms_pkg.sv
rtl/i2cms_front.sv
rtl/i2cms_engine.sv
rtl/i2cms_out_queue.sv
rtl/i2c_master_byte_sequencer_unit.sv
bench/i2c_master_byte_sequencer_unit_tb.sv
